### rtl/core/hcb_pkg.sv
// Shared types, codes and constants for the hop channel ban manager.
package hcb_pkg;

  localparam int NUM_CHANNELS_DEF = 32;
  localparam int HOP_STRIDE       = 4;
  localparam int QUALITY_SCALE    = 100;
  localparam int QUALITY_SHIFT    = 7;
  localparam logic [6:0] QUALITY_RESET = 7'd100;

  // Event codes carried in the action field.
  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_HOP    = 3'd1;
  localparam logic [2:0] ACT_BAD    = 3'd2;
  localparam logic [2:0] ACT_SAMPLE = 3'd3;
  localparam logic [2:0] ACT_WINDOW = 3'd4;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BAN_TIME     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_CHANNELS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_QUAL_THRESH  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_AVOID_BANNED = 2'd3;

  localparam logic [7:0] BAN_TIME_RESET     = 8'd100;
  localparam logic [5:0] MIN_CHANNELS_RESET = 6'd8;
  localparam logic [6:0] QUAL_THRESH_RESET  = 7'd20;
  localparam logic       AVOID_BANNED_RESET = 1'b1;

  typedef struct packed {
    logic [2:0] action;
    logic [4:0] channel;
    logic [4:0] random_start;
    logic [6:0] quality_code;
    logic       packets_seen;
  } hcb_in_t;

  typedef struct packed {
    logic [4:0] hop_channel;
    logic [5:0] banned_count;
    logic       link_alive;
    logic       channel_banned;
  } hcb_out_t;

  // Operations of the shared step unit.
  typedef enum logic [2:0] {
    UOP_NONE  = 3'd0,
    UOP_INC1  = 3'd1,
    UOP_INC4  = 3'd2,
    UOP_DEC   = 3'd3,
    UOP_GT    = 3'd4,
    UOP_SCALE = 3'd5
  } hcb_uop_t;

  typedef struct packed {
    hcb_uop_t   op;
    logic [7:0] a;
    logic [7:0] b;
  } hcb_ureq_t;

  typedef struct packed {
    logic [7:0] res;
    logic       flag;
  } hcb_ursp_t;

endpackage

### rtl/core/hcb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module hcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/hcb_unit.sv
// Shared step unit: index stepping, timer decrement, compare and quality scaling.
module hcb_unit import hcb_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  hcb_ureq_t req,
  output hcb_ursp_t rsp
);

  localparam logic [8:0] NC9 = 9'(NUM_CHANNELS);

  logic [8:0]  step_sum;
  logic [13:0] prod;

  always_comb begin
    rsp      = '0;
    step_sum = '0;
    prod     = '0;
    unique case (req.op)
      UOP_INC1, UOP_INC4: begin
        // The index is below the channel count, so one subtract wraps it.
        step_sum = {1'b0, req.a} + ((req.op == UOP_INC4) ? 9'(HOP_STRIDE) : 9'd1);
        if (step_sum >= NC9) begin
          step_sum = step_sum - NC9;
        end
        rsp.res = step_sum[7:0];
      end
      UOP_DEC: begin
        rsp.res  = req.a - 8'd1;
        rsp.flag = (req.a == 8'd1);
      end
      UOP_GT: begin
        rsp.flag = (req.a > req.b);
      end
      UOP_SCALE: begin
        prod    = 14'(({1'b0, req.a[6:0]} + 8'd1) * 14'(QUALITY_SCALE));
        rsp.res = 8'(prod >> QUALITY_SHIFT);
      end
      default: begin
        rsp = '0;
      end
    endcase
  end

endmodule

### rtl/core/hop_channel_ban_manager.sv
// A bad report bans its channel and a quality sample stores the scaled quality. A tick reads and
// decrements each banned timer, then clears all bans if min_channels or fewer channels are free.
// A window check does one quality RAM read and compare per channel. A hop steps past used channels
// and skips banned ones (a new hop cycle starts when every channel was already used).
// One word is worked on at a time; the result register frees the input while a result waits.
// Reset (synchronous, active high) clears all bans, used marks and quality entries (read as 100)
// and restores the configuration registers in the same cycle.
module hop_channel_ban_manager import hcb_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   ev_valid,
  output logic                   ev_stall,
  input  hcb_in_t                ev_word,
  output logic                   res_valid,
  input  logic                   res_stall,
  output hcb_out_t               res_word,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data
);

  localparam int CW   = $clog2(NUM_CHANNELS);
  localparam int CNTW = $clog2(NUM_CHANNELS + 1);
  localparam logic [CW-1:0]   LAST_CH  = CW'(NUM_CHANNELS - 1);
  localparam logic [CNTW-1:0] STEPS_M1 = CNTW'(NUM_CHANNELS - 1);
  localparam logic [CNTW-1:0] STEPS    = CNTW'(NUM_CHANNELS);
  localparam logic [8:0]      NC9      = 9'(NUM_CHANNELS);

  typedef enum logic [12:0] {
    ST_IDLE      = 13'b0000000000001,
    ST_TICK_RD   = 13'b0000000000010,
    ST_TICK_WR   = 13'b0000000000100,
    ST_TICK_END  = 13'b0000000001000,
    ST_HOP_USED  = 13'b0000000010000,
    ST_HOP_BAN   = 13'b0000000100000,
    ST_BAN       = 13'b0000001000000,
    ST_QUAL      = 13'b0000010000000,
    ST_WIN_WR    = 13'b0000100000000,
    ST_WIN_RD    = 13'b0001000000000,
    ST_WIN_CHK   = 13'b0010000000000,
    ST_WIN_APPLY = 13'b0100000000000,
    ST_DONE      = 13'b1000000000000
  } state_t;

  state_t state;

  logic [7:0] ban_time;
  logic [5:0] min_channels;
  logic [6:0] quality_threshold;
  logic       avoid_banned;

  logic [2:0]      act;
  logic [CW-1:0]   ch;
  logic [6:0]      qcode;
  logic            seen;
  logic [CW-1:0]   cand;
  logic [CW-1:0]   idx;
  logic [CNTW-1:0] cnt;
  logic [CNTW-1:0] count;
  logic            alive;
  logic [6:0]      qsel;

  // A set bit means the channel's timer is nonzero; the RAM holds the timer value.
  logic [NUM_CHANNELS-1:0] ban_bits;
  logic [NUM_CHANNELS-1:0] used_bits;
  // Quality entries never written since reset read as the reset quality.
  logic [NUM_CHANNELS-1:0] qvalid;

  hcb_ureq_t ureq;
  hcb_ursp_t ursp;

  logic          tim_we;
  logic [CW-1:0] tim_waddr;
  logic [7:0]    tim_wdata;
  logic [7:0]    tim_rdata;
  logic          q_we;
  logic [CW-1:0] q_waddr;
  logic [6:0]    q_wdata;
  logic [6:0]    q_rdata;

  logic          ev_accept;
  logic          do_ban;
  logic          do_unban;
  logic [7:0]    ban_load;
  logic [6:0]    qeff;
  logic [8:0]    limit;
  logic [7:0]    cand8;
  logic [7:0]    count8;
  logic [CW-1:0] report;

  function automatic logic [7:0] reduce_ch(input logic [4:0] v);
    logic [7:0] r;
    r = {3'b000, v};
    for (int k = 0; k < 4; k++) begin
      if ({1'b0, r} >= NC9) begin
        r = 8'({1'b0, r} - NC9);
      end
    end
    return r;
  endfunction

  assign ev_stall  = (state != ST_IDLE);
  assign ev_accept = ev_valid && !ev_stall;

  assign ban_load = (ban_time == 8'd0) ? 8'd1 : ban_time;
  assign qeff     = qvalid[idx] ? q_rdata : QUALITY_RESET;
  assign limit    = (9'(min_channels) > NC9) ? 9'd0 : NC9 - 9'(min_channels);
  assign cand8    = 8'(cand);
  assign count8   = 8'(count);
  assign report   = (act == ACT_HOP) ? cand : ch;

  assign do_ban   = !ban_bits[ch] && ((state == ST_BAN) ||
                    ((state == ST_WIN_APPLY) && alive && !ursp.flag));
  assign do_unban = ban_bits[ch] && (state == ST_WIN_APPLY) && alive && ursp.flag;

  // Request to the shared unit, by state.
  always_comb begin
    ureq = '{op: UOP_NONE, a: 8'd0, b: 8'd0};
    unique case (state)
      ST_HOP_USED:  ureq = '{op: UOP_INC1, a: cand8, b: 8'd0};
      ST_HOP_BAN:   ureq = '{op: UOP_INC4, a: cand8, b: 8'd0};
      ST_TICK_WR:   ureq = '{op: UOP_DEC, a: tim_rdata, b: 8'd0};
      ST_QUAL:      ureq = '{op: UOP_SCALE, a: {1'b0, qcode}, b: 8'd0};
      ST_WIN_CHK:   ureq = '{op: UOP_GT, a: {1'b0, qeff}, b: {1'b0, quality_threshold}};
      ST_WIN_APPLY: ureq = '{op: UOP_GT, a: {1'b0, qsel}, b: {1'b0, quality_threshold}};
      default:      ureq = '{op: UOP_NONE, a: 8'd0, b: 8'd0};
    endcase
  end

  hcb_unit #(.NUM_CHANNELS(NUM_CHANNELS)) u_unit (
    .req (ureq),
    .rsp (ursp)
  );

  always_comb begin
    tim_we    = 1'b0;
    tim_waddr = ch;
    tim_wdata = ban_load;
    if (state == ST_TICK_WR) begin
      tim_we    = 1'b1;
      tim_waddr = idx;
      tim_wdata = ursp.res;
    end else if (do_ban) begin
      tim_we = 1'b1;
    end
  end

  always_comb begin
    q_we    = 1'b0;
    q_wdata = 7'd0;
    if (state == ST_QUAL) begin
      q_we    = 1'b1;
      q_wdata = ursp.res[6:0];
    end else if ((state == ST_WIN_WR) && !seen) begin
      q_we = 1'b1;
    end
  end
  assign q_waddr = ch;

  hcb_ram #(.WIDTH(8), .DEPTH(NUM_CHANNELS)) u_timer_ram (
    .clk   (clk),
    .we    (tim_we),
    .waddr (tim_waddr),
    .wdata (tim_wdata),
    .raddr (idx),
    .rdata (tim_rdata)
  );

  hcb_ram #(.WIDTH(7), .DEPTH(NUM_CHANNELS)) u_quality_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (idx),
    .rdata (q_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ban_time          <= BAN_TIME_RESET;
      min_channels      <= MIN_CHANNELS_RESET;
      quality_threshold <= QUAL_THRESH_RESET;
      avoid_banned      <= AVOID_BANNED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BAN_TIME:     ban_time          <= cfg_data;
        CFG_MIN_CHANNELS: min_channels      <= cfg_data[5:0];
        CFG_QUAL_THRESH:  quality_threshold <= cfg_data[6:0];
        CFG_AVOID_BANNED: avoid_banned      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ban_bits  <= '0;
      used_bits <= '0;
      qvalid    <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall && (state != ST_DONE)) begin
        res_valid <= 1'b0;
      end
      if (do_ban) begin
        ban_bits[ch] <= 1'b1;
        count        <= count + CNTW'(1);
      end
      if (do_unban) begin
        ban_bits[ch] <= 1'b0;
        count        <= count - CNTW'(1);
      end
      if (q_we) begin
        qvalid[ch] <= 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          if (ev_accept) begin
            act   <= ev_word.action;
            ch    <= CW'(reduce_ch(ev_word.channel));
            cand  <= CW'(reduce_ch(ev_word.random_start));
            qcode <= ev_word.quality_code;
            seen  <= ev_word.packets_seen;
            idx   <= '0;
            cnt   <= '0;
            alive <= 1'b0;
            unique case (ev_word.action)
              ACT_TICK:   state <= ST_TICK_RD;
              ACT_HOP:    state <= ST_HOP_USED;
              ACT_BAD:    state <= ST_BAN;
              ACT_SAMPLE: state <= ST_QUAL;
              ACT_WINDOW: state <= ST_WIN_WR;
              default:    state <= ST_DONE;
            endcase
          end
        end
        ST_TICK_RD: begin
          if (ban_bits[idx]) begin
            state <= ST_TICK_WR;
          end else if (idx == LAST_CH) begin
            state <= ST_TICK_END;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        ST_TICK_WR: begin
          if (ursp.flag) begin
            ban_bits[idx] <= 1'b0;
            count         <= count - CNTW'(1);
          end
          if (idx == LAST_CH) begin
            state <= ST_TICK_END;
          end else begin
            idx   <= idx + CW'(1);
            state <= ST_TICK_RD;
          end
        end
        ST_TICK_END: begin
          if (9'(count) >= limit) begin
            ban_bits <= '0;
            count    <= '0;
          end
          state <= ST_DONE;
        end
        ST_HOP_USED: begin
          if (!used_bits[cand]) begin
            used_bits[cand] <= 1'b1;
            cnt             <= '0;
            state           <= ST_HOP_BAN;
          end else if (cnt == STEPS_M1) begin
            // Every channel was used: start a new hop cycle at the start channel.
            used_bits <= {{(NUM_CHANNELS-1){1'b0}}, 1'b1} << CW'(ursp.res);
            cand      <= CW'(ursp.res);
            cnt       <= '0;
            state     <= ST_HOP_BAN;
          end else begin
            cand <= CW'(ursp.res);
            cnt  <= cnt + CNTW'(1);
          end
        end
        ST_HOP_BAN: begin
          if (!avoid_banned || !ban_bits[cand] || (cnt == STEPS)) begin
            state <= ST_DONE;
          end else begin
            cand <= CW'(ursp.res);
            cnt  <= cnt + CNTW'(1);
          end
        end
        ST_BAN: begin
          state <= ST_DONE;
        end
        ST_QUAL: begin
          state <= ST_DONE;
        end
        ST_WIN_WR: begin
          state <= ST_WIN_RD;
        end
        ST_WIN_RD: begin
          state <= ST_WIN_CHK;
        end
        ST_WIN_CHK: begin
          if (ursp.flag) begin
            alive <= 1'b1;
          end
          if (idx == ch) begin
            qsel <= qeff;
          end
          if (idx == LAST_CH) begin
            state <= ST_WIN_APPLY;
          end else begin
            idx   <= idx + CW'(1);
            state <= ST_WIN_RD;
          end
        end
        ST_WIN_APPLY: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!res_valid || !res_stall) begin
            res_word.hop_channel    <= (act == ACT_HOP) ? cand8[4:0] : 5'd0;
            res_word.banned_count   <= count8[5:0];
            res_word.link_alive     <= alive;
            res_word.channel_banned <= ban_bits[report];
            res_valid               <= 1'b1;
            state                   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
